/* rtl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types for the max-heap priority queue: controller states, status
// codes and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_RDLAST,
        S_DN_LAST,
        S_DN_CHK,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_DEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start_push;
        logic start_pop;
        logic set_full;
        logic set_empty;
        logic rd_parent;
        logic rd_last;
        logic rd_left;
        logic rd_right;
        logic ld_val;
        logic take_left;
        logic take_right;
        logic wr_val;
        logic wr_move_up;
        logic wr_move_down;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic count_full;
        logic count_zero;
        logic pos_zero;
        logic val_lt_rd;
        logic left_out;
        logic right_in;
        logic best_is_pos;
        logic out_busy;
    } t_dp_sts;

endpackage

/* rtl/max_heap_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Binary max-heap priority queue with push and pop transactions and a
// status result for every transaction.
// ----------------------------------------------------------------------------
// Each input transaction pushes a signed value (s_axis_tuser = 0) or pops the
// largest entry (s_axis_tuser = 1) and yields exactly one result carrying the
// new top value (zero when empty), the entry count, an empty flag and a status
// (ok, push dropped on full, pop on empty). Work runs one transaction at a
// time on a single-port heap memory with registered read data. A push reads
// one parent per level climbed; a pop first reads the last entry, then for
// each level descended reads the left child and, if present, the right child.
// Rejected operations go straight to the result. The result register frees
// the input side as soon as the result is loaded, so a new transaction is
// taken while the previous result waits on m_axis_tready. The store is not
// cleared after reset.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // value
    input  logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // top_value, entry_count
    output logic [((VALUE_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
    // is_empty, status
    output logic [2:0]               m_axis_tuser
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_W = ((VALUE_BITS + CNT_W + 7) / 8) * 8;

    mhpq_pkg::t_dp_cmd            cmd;
    mhpq_pkg::t_dp_sts            sts;
    logic signed [VALUE_BITS-1:0] top_value;
    logic                         is_empty;
    logic [CNT_W-1:0]             entry_count;
    mhpq_pkg::t_status            status;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mhpq_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_value       (s_axis_tdata[VALUE_BITS-1:0]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_top_value   (top_value),
        .o_is_empty    (is_empty),
        .o_entry_count (entry_count),
        .o_status      (status)
    );

    assign m_axis_tdata = OUT_W'({entry_count, top_value});
    assign m_axis_tuser = {status, is_empty};

endmodule

/* rtl/mhpq_datapath.sv */
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap store, sift position and carried value, child selection and the
// registered result.
// ----------------------------------------------------------------------------
module mhpq_datapath #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mhpq_pkg::t_dp_cmd            i_cmd,
    output mhpq_pkg::t_dp_sts            o_sts,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [VALUE_BITS-1:0] o_top_value,
    output logic                         o_is_empty,
    output logic [CNT_W-1:0]             o_entry_count,
    output mhpq_pkg::t_status            o_status
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int EW     = CNT_W + 1;

    logic signed [VALUE_BITS-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]             r_count;
    logic [ADDR_W-1:0]            r_pos;
    logic [ADDR_W-1:0]            r_best;
    logic signed [VALUE_BITS-1:0] r_val;
    logic signed [VALUE_BITS-1:0] r_bestval;
    logic signed [VALUE_BITS-1:0] r_rd;
    logic signed [VALUE_BITS-1:0] r_top;
    mhpq_pkg::t_status            r_status;
    logic                         r_o_valid;

    logic [ADDR_W-1:0]            parent;
    logic [EW-1:0]                left_e;
    logic [EW-1:0]                right_e;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         wr_en;
    logic signed [VALUE_BITS-1:0] wr_data;

    assign parent  = ADDR_W'(r_pos - ADDR_W'(1)) >> 1;
    assign left_e  = EW'({r_pos, 1'b1});
    assign right_e = left_e + EW'(1);

    always_comb begin
        rd_en   = i_cmd.rd_parent | i_cmd.rd_last | i_cmd.rd_left | i_cmd.rd_right;
        rd_addr = parent;
        if (i_cmd.rd_last) begin
            rd_addr = r_count[ADDR_W-1:0];
        end else if (i_cmd.rd_left) begin
            rd_addr = left_e[ADDR_W-1:0];
        end else if (i_cmd.rd_right) begin
            rd_addr = right_e[ADDR_W-1:0];
        end
        wr_en   = i_cmd.wr_val | i_cmd.wr_move_up | i_cmd.wr_move_down;
        wr_data = r_val;
        if (i_cmd.wr_move_up) begin
            wr_data = r_rd;
        end else if (i_cmd.wr_move_down) begin
            wr_data = r_bestval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_pos] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.start_push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.start_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_push) begin
            r_val    <= i_value;
            r_pos    <= r_count[ADDR_W-1:0];
            r_status <= mhpq_pkg::ST_OK;
        end
        if (i_cmd.start_pop) begin
            r_pos    <= '0;
            r_status <= mhpq_pkg::ST_OK;
        end
        if (i_cmd.set_full) begin
            r_status <= mhpq_pkg::ST_FULL;
        end
        if (i_cmd.set_empty) begin
            r_status <= mhpq_pkg::ST_EMPTY;
        end
        if (i_cmd.ld_val) begin
            r_val <= r_rd;
        end
        if (i_cmd.take_left) begin
            if (r_val < r_rd) begin
                r_best    <= left_e[ADDR_W-1:0];
                r_bestval <= r_rd;
            end else begin
                r_best    <= r_pos;
                r_bestval <= r_val;
            end
        end
        if (i_cmd.take_right && (r_bestval < r_rd)) begin
            r_best    <= right_e[ADDR_W-1:0];
            r_bestval <= r_rd;
        end
        if (i_cmd.wr_move_up) begin
            r_pos <= parent;
        end
        if (i_cmd.wr_move_down) begin
            r_pos <= r_best;
        end
        if (wr_en && (r_pos == '0)) begin
            r_top <= wr_data;
        end
        if (i_cmd.out_load) begin
            o_top_value   <= (r_count == '0) ? '0 : r_top;
            o_is_empty    <= (r_count == '0);
            o_entry_count <= r_count;
            o_status      <= r_status;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_sts.count_full  = (r_count == CNT_W'(CAPACITY));
    assign o_sts.count_zero  = (r_count == '0);
    assign o_sts.pos_zero    = (r_pos == '0);
    assign o_sts.val_lt_rd   = (r_val < r_rd);
    assign o_sts.left_out    = (left_e >= EW'(r_count));
    assign o_sts.right_in    = (right_e < EW'(r_count));
    assign o_sts.best_is_pos = (r_best == r_pos);
    assign o_sts.out_busy    = r_o_valid & ~i_out_ready;

endmodule

/* rtl/mhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for push sift-up, pop sift-down and result hand-off.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_op,
    output logic               o_in_ready,
    input  mhpq_pkg::t_dp_sts  i_sts,
    output mhpq_pkg::t_dp_cmd  o_cmd
);

    mhpq_pkg::t_state r_state;
    mhpq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mhpq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_op) begin
                        if (i_sts.count_full) begin
                            o_cmd.set_full = 1'b1;
                            n_state        = mhpq_pkg::S_DONE;
                        end else begin
                            o_cmd.start_push = 1'b1;
                            n_state          = mhpq_pkg::S_UP_CHK;
                        end
                    end else begin
                        if (i_sts.count_zero) begin
                            o_cmd.set_empty = 1'b1;
                            n_state         = mhpq_pkg::S_DONE;
                        end else begin
                            o_cmd.start_pop = 1'b1;
                            n_state         = mhpq_pkg::S_DN_RDLAST;
                        end
                    end
                end
            end
            mhpq_pkg::S_UP_CHK: begin
                if (i_sts.pos_zero) begin
                    o_cmd.wr_val = 1'b1;
                    n_state      = mhpq_pkg::S_DONE;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                if (i_sts.val_lt_rd) begin
                    o_cmd.wr_val = 1'b1;
                    n_state      = mhpq_pkg::S_DONE;
                end else begin
                    o_cmd.wr_move_up = 1'b1;
                    n_state          = mhpq_pkg::S_UP_CHK;
                end
            end
            mhpq_pkg::S_DN_RDLAST: begin
                o_cmd.rd_last = 1'b1;
                n_state       = mhpq_pkg::S_DN_LAST;
            end
            mhpq_pkg::S_DN_LAST: begin
                o_cmd.ld_val = 1'b1;
                n_state      = mhpq_pkg::S_DN_CHK;
            end
            mhpq_pkg::S_DN_CHK: begin
                if (i_sts.left_out) begin
                    o_cmd.wr_val = 1'b1;
                    n_state      = mhpq_pkg::S_DONE;
                end else begin
                    o_cmd.rd_left = 1'b1;
                    n_state       = mhpq_pkg::S_DN_LEFT;
                end
            end
            mhpq_pkg::S_DN_LEFT: begin
                o_cmd.take_left = 1'b1;
                if (i_sts.right_in) begin
                    o_cmd.rd_right = 1'b1;
                    n_state        = mhpq_pkg::S_DN_RIGHT;
                end else begin
                    n_state = mhpq_pkg::S_DN_DEC;
                end
            end
            mhpq_pkg::S_DN_RIGHT: begin
                o_cmd.take_right = 1'b1;
                n_state          = mhpq_pkg::S_DN_DEC;
            end
            mhpq_pkg::S_DN_DEC: begin
                if (i_sts.best_is_pos) begin
                    o_cmd.wr_val = 1'b1;
                    n_state      = mhpq_pkg::S_DONE;
                end else begin
                    o_cmd.wr_move_down = 1'b1;
                    n_state            = mhpq_pkg::S_DN_CHK;
                end
            end
            mhpq_pkg::S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* tb/tb_max_heap_priority_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue_core
// Self-checking bench for the max-heap priority queue core. A short table of
// push and pop transactions covers the value extremes, ties and the empty
// store. Random runs follow: they fill the store to overflow, drain it past
// empty, and mix pushes and pops. Each accepted transaction goes through a
// heap predictor kept inside the bench. Every result is compared field by
// field with the oldest prediction. Source gaps and sink back-pressure are
// varied over three phases.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue_core;

    localparam int CAPACITY     = 64;
    localparam int VALUE_BITS   = 32;
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
    localparam int S_DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W     = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 342;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [VALUE_BITS-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_BITS-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] top;
        logic                         empty;
        logic [COUNT_BITS-1:0]        count;
        mhpq_pkg::t_status            status;
    } t_heap_result;

    typedef struct {
        logic                  op;
        logic [VALUE_BITS-1:0] value;
        bit                    fixed;
        t_heap_result          res;
    } t_step_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;    // value
    logic                  s_axis_tuser;    // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;    // top_value, entry_count
    logic [2:0]            m_axis_tuser;    // is_empty, status

    logic signed [VALUE_BITS-1:0] heap_vals [CAPACITY];
    int                           heap_fill = 0;
    t_heap_result                 pending_results [$];
    t_step_row                    dir_rows [$];
    int                           src_idle_pct = 10;
    int                           dst_stall_pct = 78;
    int                           err_count = 0;
    int                           cycle_count = 0;

    max_heap_priority_queue_core #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_heap_result heap_apply(logic op, logic signed [VALUE_BITS-1:0] val);
        t_heap_result                 r;
        int                           pos;
        int                           parent;
        int                           lc;
        int                           rc;
        int                           big;
        bit                           settled;
        logic signed [VALUE_BITS-1:0] tmp;
        r.status = mhpq_pkg::ST_OK;
        if (op == OP_PUSH) begin
            if (heap_fill >= CAPACITY) begin
                r.status = mhpq_pkg::ST_FULL;
            end else begin
                pos = heap_fill;
                heap_vals[pos] = val;
                heap_fill++;
                settled = 1'b0;
                while (pos > 0 && !settled) begin
                    parent = (pos - 1) / 2;
                    if (heap_vals[pos] < heap_vals[parent]) begin
                        settled = 1'b1;
                    end else begin
                        tmp = heap_vals[pos];
                        heap_vals[pos] = heap_vals[parent];
                        heap_vals[parent] = tmp;
                        pos = parent;
                    end
                end
            end
        end else if (heap_fill == 0) begin
            r.status = mhpq_pkg::ST_EMPTY;
        end else begin
            heap_fill--;
            heap_vals[0] = heap_vals[heap_fill];
            pos = 0;
            settled = 1'b0;
            while (!settled) begin
                lc  = 2 * pos + 1;
                rc  = lc + 1;
                big = pos;
                if (lc < heap_fill && heap_vals[big] < heap_vals[lc])
                    big = lc;
                if (rc < heap_fill && heap_vals[big] < heap_vals[rc])
                    big = rc;
                if (big == pos) begin
                    settled = 1'b1;
                end else begin
                    tmp = heap_vals[pos];
                    heap_vals[pos] = heap_vals[big];
                    heap_vals[big] = tmp;
                    pos = big;
                end
            end
        end
        r.top   = (heap_fill > 0) ? heap_vals[0] : '0;
        r.empty = (heap_fill == 0);
        r.count = COUNT_BITS'(heap_fill);
        return r;
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        logic [VALUE_BITS-1:0] r;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       r = VAL_MAX;
                    1:       r = VAL_MIN;
                    2:       r = '0;
                    default: r = '1;
                endcase
            end
            1, 2:    r = $urandom_range(0, 8) - 32'd4;
            default: r = $urandom;
        endcase
        return r;
    endfunction

    task automatic add_row(logic op, logic [VALUE_BITS-1:0] val, bit fixed,
                           logic [VALUE_BITS-1:0] top, logic empty,
                           int count, mhpq_pkg::t_status status);
        t_step_row row;
        row.op         = op;
        row.value      = val;
        row.fixed      = fixed;
        row.res.top    = top;
        row.res.empty  = empty;
        row.res.count  = COUNT_BITS'(count);
        row.res.status = status;
        dir_rows = {dir_rows, row};
    endtask

    task automatic send_txn(logic op, logic [VALUE_BITS-1:0] val, bit fixed,
                            t_heap_result typed);
        t_heap_result pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = heap_apply(op, val);
        if (fixed)
            pred = typed;
        pending_results = {pending_results, pred};
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(int n_items);
        int  sent;
        int  len;
        int  push_pct;
        bit  first;
        logic op;
        sent  = 0;
        first = 1'b1;
        while (sent < n_items) begin
            case (first ? 0 : $urandom_range(0, 4))
                0: begin
                    len      = CAPACITY - heap_fill + $urandom_range(1, 3);
                    push_pct = 100;
                end
                1: begin
                    len      = heap_fill + $urandom_range(1, 3);
                    push_pct = 0;
                end
                default: begin
                    len      = $urandom_range(10, 40);
                    push_pct = $urandom_range(25, 75);
                end
            endcase
            first = 1'b0;
            for (int i = 0; i < len && sent < n_items; i++) begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                send_txn(op, rand_value(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_heap_result          want;
        logic [VALUE_BITS-1:0] got_top;
        logic [COUNT_BITS-1:0] got_count;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no prediction pending");
                err_count++;
            end else begin
                want      = pending_results.pop_front();
                got_top   = m_axis_tdata[VALUE_BITS-1:0];
                got_count = m_axis_tdata[VALUE_BITS +: COUNT_BITS];
                if (got_top !== want.top) begin
                    $error("top_value expected %0d got %0d", want.top, $signed(got_top));
                    err_count++;
                end
                if (m_axis_tuser[0] !== want.empty) begin
                    $error("is_empty expected %0b got %0b", want.empty, m_axis_tuser[0]);
                    err_count++;
                end
                if (got_count !== want.count) begin
                    $error("entry_count expected %0d got %0d", want.count, got_count);
                    err_count++;
                end
                if (m_axis_tuser[2:1] !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_axis_tuser[2:1]);
                    err_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= dst_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUSH;

        add_row(OP_POP,  32'h0000_0000, 1, 32'h0,  1, 0, mhpq_pkg::ST_EMPTY);
        add_row(OP_PUSH, VAL_MAX,       1, VAL_MAX, 0, 1, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, VAL_MIN,       1, VAL_MAX, 0, 2, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'h0000_0000, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'hFFFF_FFFF, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'h0000_0001, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'h5555_5555, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'hAAAA_AAAA, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'h0000_0001, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        for (int i = 0; i < 7; i++)
            add_row(OP_POP, $urandom, 0, 32'h0, 0, 0, mhpq_pkg::ST_OK);
        add_row(OP_POP,  32'hFFFF_FFFF, 1, 32'h0,  1, 0, mhpq_pkg::ST_OK);
        add_row(OP_POP,  32'h1234_5678, 1, 32'h0,  1, 0, mhpq_pkg::ST_EMPTY);
        add_row(OP_PUSH, VAL_MIN,       1, VAL_MIN, 0, 1, mhpq_pkg::ST_OK);
        add_row(OP_POP,  32'h0000_0000, 1, 32'h0,  1, 0, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'hFFFF_FFFB, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'hFFFF_FFFB, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_PUSH, 32'hFFFF_FFFE, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_POP,  32'h0000_0000, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_POP,  32'h0000_0000, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);
        add_row(OP_POP,  32'h0000_0000, 0, 32'h0,  0, 0, mhpq_pkg::ST_OK);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 10;
        dst_stall_pct = 78;
        foreach (dir_rows[i])
            send_txn(dir_rows[i].op, dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].res);
        run_random(PHASE_ITEMS);
        wait_drained();

        src_idle_pct  = 78;
        dst_stall_pct = 10;
        run_random(PHASE_ITEMS);
        wait_drained();

        src_idle_pct  = 0;
        dst_stall_pct = 0;
        run_random(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/mhpq_pkg.sv
rtl/mhpq_datapath.sv
rtl/mhpq_ctrl.sv
rtl/max_heap_priority_queue_core.sv
tb/tb_max_heap_priority_queue_core.sv
